// ===== sv/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LENBLK,
      ST_ROUND,
      ST_ADD,
      ST_DONE
   } state_type;

   localparam int unsigned NUM_WORDS = 16;
   localparam int unsigned NUM_HASH  = 8;
   localparam int unsigned NUM_ROUND = 64;
   localparam int unsigned LEN_POS   = 56;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;

   localparam logic [31:0] K_TABLE [NUM_ROUND] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [NUM_HASH] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// ===== sv/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: byte buffer, round sequencer and digest register.
//
// Usage: the req channel carries one message byte per item (req_has_byte marks a byte,
// req_last ends the message). The rsp channel carries one 256-bit digest per message,
// split in four 64-bit fields, first digest byte in the top bits of the first field.
// Both channels use valid/stall; an item moves when valid is high and stall is low.
// A byte that does not complete a 64-byte block is taken without raising req_stall.
// A byte that completes a block holds req_stall high while the single
// round unit runs 64 rounds (one per cycle) and the add state adds into the hash words.
// For the last item, each final block runs a setup state, the rounds and the add (one final
// block, or two when 56 or more bytes remain), then the digest register is loaded.
// A digest waits in the output register while the next message is taken; a finished
// digest waits inside the block only while the previous one is still stalled.
// Reset (synchronous, active high) loads the initial hash words, clears the byte count
// and length, and drops rsp_valid.
module sha256_byte_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_bytes_0_to_7,
   output logic [63:0] rsp_digest_bytes_8_to_15,
   output logic [63:0] rsp_digest_bytes_16_to_23,
   output logic [63:0] rsp_digest_bytes_24_to_31
);

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [5:0]  round_ff;
   logic        last_pend_ff;
   logic        fin_ff;
   logic        lenblk_ff;
   logic        rsp_valid_ff;
   logic [31:0] w_ff    [NUM_WORDS];
   logic [31:0] hash_ff [NUM_HASH];
   logic [31:0] v_ff    [NUM_HASH];
   logic [63:0] digest_ff [4];

   logic        accept;
   logic        load_out;
   logic        block_full;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] w_next;

   assign block_full = (fill_ff == 6'd63);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_has_byte && block_full) begin
                  state_in = ST_ROUND;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD:    state_in = ST_ROUND;
         ST_LENBLK: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fin_ff) begin
               state_in = ST_DONE;
            end else if (lenblk_ff) begin
               state_in = ST_LENBLK;
            end else if (last_pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_DONE: load_out  = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
            load_out  = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   assign t1 = v_ff[7] + big_s1(v_ff[4]) + choose(v_ff[4], v_ff[5], v_ff[6])
             + K_TABLE[round_ff] + w_ff[0];
   assign t2 = big_s0(v_ff[0]) + majority(v_ff[0], v_ff[1], v_ff[2]);
   assign w_next = small_s1(w_ff[14]) + w_ff[9] + small_s0(w_ff[1]) + w_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         last_pend_ff <= 1'b0;
         fin_ff       <= 1'b0;
         lenblk_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_HASH; i++) begin
            hash_ff[i] <= INIT_H[i];
         end
      end else begin
         state_ff <= state_in;
         if (accept) begin
            last_pend_ff <= req_has_byte && block_full && req_last;
            if (req_has_byte) begin
               fill_ff <= fill_ff + 6'd1;
               bits_ff <= bits_ff + 64'd8;
            end
         end
         if (state_ff == ST_ROUND) begin
            round_ff <= round_ff + 6'd1;
         end else begin
            round_ff <= '0;
         end
         if (state_ff == ST_PAD) begin
            last_pend_ff <= 1'b0;
            fin_ff       <= (fill_ff < 6'(LEN_POS));
            lenblk_ff    <= (fill_ff >= 6'(LEN_POS));
         end
         if (state_ff == ST_LENBLK) begin
            fin_ff    <= 1'b1;
            lenblk_ff <= 1'b0;
         end
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < NUM_HASH; i++) begin
               hash_ff[i] <= hash_ff[i] + v_ff[i];
            end
         end
         if (load_out) begin
            fill_ff      <= '0;
            bits_ff      <= '0;
            fin_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < NUM_HASH; i++) begin
               hash_ff[i] <= INIT_H[i];
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // byte buffer, doubling as the message schedule window
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_has_byte) begin
               w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_data_byte;
            end
         end
         ST_PAD: begin
            for (int j = 0; j < NUM_WORDS; j++) begin
               if (j < NUM_WORDS - 2 || fill_ff >= 6'(LEN_POS)) begin
                  for (int b = 0; b < 4; b++) begin
                     if (6'(4 * j + b) == fill_ff) begin
                        w_ff[j][8 * (3 - b) +: 8] <= PAD_BYTE;
                     end else if (6'(4 * j + b) > fill_ff) begin
                        w_ff[j][8 * (3 - b) +: 8] <= 8'd0;
                     end
                  end
               end
            end
            if (fill_ff < 6'(LEN_POS)) begin
               w_ff[NUM_WORDS - 2] <= bits_ff[63:32];
               w_ff[NUM_WORDS - 1] <= bits_ff[31:0];
            end
         end
         ST_LENBLK: begin
            for (int j = 0; j < NUM_WORDS - 2; j++) begin
               w_ff[j] <= '0;
            end
            w_ff[NUM_WORDS - 2] <= bits_ff[63:32];
            w_ff[NUM_WORDS - 1] <= bits_ff[31:0];
         end
         ST_ROUND: begin
            for (int j = 0; j < NUM_WORDS - 1; j++) begin
               w_ff[j] <= w_ff[j + 1];
            end
            w_ff[NUM_WORDS - 1] <= w_next;
         end
         default: begin
         end
      endcase
   end

   // working variables: run a round, else track the hash words
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else begin
         for (int i = 0; i < NUM_HASH; i++) begin
            v_ff[i] <= hash_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int i = 0; i < 4; i++) begin
            digest_ff[i] <= {hash_ff[2 * i], hash_ff[2 * i + 1]};
         end
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_digest_bytes_0_to_7   = digest_ff[0];
   assign rsp_digest_bytes_8_to_15  = digest_ff[1];
   assign rsp_digest_bytes_16_to_23 = digest_ff[2];
   assign rsp_digest_bytes_24_to_31 = digest_ff[3];

`ifndef SYNTHESIS
   a_round_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (round_ff == 6'd0))
      else $error("round counter running outside the round state");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      !(fin_ff && lenblk_ff))
      else $error("final and length-block flags both set");

   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished digest not loaded into empty output register");

   a_reinit : assert property (@(posedge clock) disable iff (reset)
      load_out |=> (fill_ff == 6'd0 && bits_ff == 64'd0 && hash_ff[0] == INIT_H[0]))
      else $error("state not reinitialized after digest");
`endif

endmodule

// ===== bench/sha256_byte_stream_hasher_check.sv =====
// Checker for the SHA-256 byte stream hasher: predicts each digest and compares the rsp items.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_check
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_digest_bytes_0_to_7,
   input  logic [63:0] rsp_digest_bytes_8_to_15,
   input  logic [63:0] rsp_digest_bytes_16_to_23,
   input  logic [63:0] rsp_digest_bytes_24_to_31,
   output int          fail_count,
   output int          pending_digests,
   output int          digests_checked
);

   logic [31:0]  hash_state [NUM_HASH];
   logic [7:0]   block_buf [64];
   logic [5:0]   fill;
   logic [63:0]  bit_len;
   logic [255:0] expected_digests [$];
   logic [255:0] want;
   logic [255:0] got;

   string field_name [4] = '{"digest_bytes_0_to_7", "digest_bytes_8_to_15",
                             "digest_bytes_16_to_23", "digest_bytes_24_to_31"};

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < NUM_HASH; i++) hash_state[i] = INIT_H[i];
      fill = '0;
      bit_len = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [NUM_ROUND];
      logic [31:0] v [NUM_HASH];
      logic [31:0] s0;
      logic [31:0] s1;
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < NUM_WORDS; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = NUM_WORDS; i < NUM_ROUND; i++) begin
         s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < NUM_HASH; i++) v[i] = hash_state[i];
      for (int i = 0; i < NUM_ROUND; i++) begin
         t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
         t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = NUM_HASH - 1; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < NUM_HASH; i++) hash_state[i] = hash_state[i] + v[i];
   endfunction

   function automatic void take_item(input logic [7:0] data, input logic has_byte,
                                     input logic last);
      if (has_byte) begin
         block_buf[fill] = data;
         fill = fill + 6'd1;
         bit_len = bit_len + 64'd8;
         if (fill == 6'd0) compress_block();
      end
      if (last) begin
         block_buf[fill] = PAD_BYTE;
         for (int i = fill + 1; i < 64; i++) block_buf[i] = 8'h00;
         if (fill >= LEN_POS) begin
            compress_block();
            for (int i = 0; i < LEN_POS; i++) block_buf[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
         compress_block();
         expected_digests.push_back({hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                     hash_state[4], hash_state[5], hash_state[6], hash_state[7]});
         restart_message();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         expected_digests.delete();
         fail_count = 0;
         digests_checked = 0;
      end else begin
         if (req_valid && !req_stall) take_item(req_data_byte, req_has_byte, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_digests.size() == 0) begin
               $error("rsp item with no digest expected");
               fail_count++;
            end else begin
               want = expected_digests.pop_front();
               got = {rsp_digest_bytes_0_to_7, rsp_digest_bytes_8_to_15,
                      rsp_digest_bytes_16_to_23, rsp_digest_bytes_24_to_31};
               for (int i = 0; i < 4; i++)
                  if (got[255 - 64*i -: 64] !== want[255 - 64*i -: 64]) begin
                     $error("%s: expected %h, got %h", field_name[i],
                            want[255 - 64*i -: 64], got[255 - 64*i -: 64]);
                     fail_count++;
                  end
               digests_checked++;
            end
         end
      end
      pending_digests = expected_digests.size();
   end

endmodule

// ===== bench/sha256_byte_stream_hasher_test.sv =====
// Testbench top for the SHA-256 byte stream hasher: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_bytes_0_to_7;
   logic [63:0] rsp_digest_bytes_8_to_15;
   logic [63:0] rsp_digest_bytes_16_to_23;
   logic [63:0] rsp_digest_bytes_24_to_31;

   int fail_count;
   int pending_digests;
   int digests_checked;

   int burst_left;
   int stall_hold;
   int item_count;
   int idle_count;
   int byte_count;
   int messages_sent;
   int longest_message;

   int edge_lengths [13] = '{0, 1, 55, 56, 57, 63, 64, 65, 111, 119, 120, 127, 128};

   sha256_byte_stream_hasher uut (.*);

   sha256_byte_stream_hasher_check checker_inst (
      .*,
      .fail_count      (fail_count),
      .pending_digests (pending_digests),
      .digests_checked (digests_checked)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
      end else begin
         rsp_stall <= 1'b1;
         stall_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 25)
                                                   : $urandom_range(0, 3);
      end
   end

   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic last);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data_byte = data;
      req_has_byte = has_byte;
      req_last = last;
      do @(posedge clock); while (req_stall);
      if (has_byte || last) item_count++;
      else idle_count++;
      if (has_byte) byte_count++;
   endtask

   task automatic send_message(input int len);
      logic [7:0] data;
      bit         separate_end;
      separate_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         case ($urandom_range(0, 9))
            0:       data = 8'h00;
            1:       data = 8'hff;
            default: data = 8'($urandom_range(0, 255));
         endcase
         send_item(data, 1'b1, !separate_end && i == len - 1);
      end
      if (separate_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      messages_sent++;
      if (len > longest_message) longest_message = len;
   endtask

   initial begin
      int len;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'haa, 1'b1, 1'b0);
      send_item(8'h3c, 1'b0, 1'b0);
      send_item(8'hc3, 1'b0, 1'b1);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      messages_sent = 8;

      while (item_count < 1150 || messages_sent < 48) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(0, 20);
            5, 6, 7:       len = edge_lengths[$urandom_range(0, 12)];
            default:       len = $urandom_range(0, 150);
         endcase
         send_message(len);
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_digests != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d messages: %0d items, %0d bytes, %0d idle items, longest %0d bytes.",
               messages_sent, item_count, byte_count, idle_count, longest_message);
      $display("Checked %0d digests, including block-boundary and empty messages.",
               digests_checked);
      if (fail_count == 0)
         $display("** sha256_byte_stream_hasher: PASSED **");
      else
         $display("** sha256_byte_stream_hasher: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d digests outstanding.", pending_digests);
      $display("** sha256_byte_stream_hasher: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sha_pkg.sv
sv/sha256_byte_stream_hasher.sv
bench/sha256_byte_stream_hasher_check.sv
bench/sha256_byte_stream_hasher_test.sv
